@@ hdl/scl_pkg.sv @@
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types, character codes and response texts of the serial command
// line responder.
// ----------------------------------------------------------------------------
package scl_pkg;

   localparam int LINE_DEPTH_DEFAULT  = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_DEL = 8'd127;
   localparam logic [7:0] CH_E   = 8'h45;
   localparam logic [7:0] CH_V   = 8'h56;
   localparam logic [7:0] CH_S   = 8'h53;
   localparam logic [7:0] CH_R   = 8'h52;
   localparam logic [7:0] CH_NUL = 8'd0;

   typedef enum logic [2:0] {
      OP_ECHO,
      OP_STORE,
      OP_ERASE,
      OP_LINE_E,
      OP_VERSION,
      OP_STATUS,
      OP_RESET,
      OP_ERROR
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      TXT_ERASE,
      TXT_ECHO,
      TXT_CRLF,
      TXT_VERSION,
      TXT_STATUS,
      TXT_RESET,
      TXT_ERROR
   } text_type;

   localparam int TXT_POS_W = 5;

   localparam int LEN_ERASE   = 3;
   localparam int LEN_ECHO    = 6;
   localparam int LEN_CRLF    = 2;
   localparam int LEN_VERSION = 14;
   localparam int LEN_STATUS  = 15;
   localparam int LEN_RESET   = 11;
   localparam int LEN_ERROR   = 24;

   localparam logic [8*LEN_ERASE-1:0]   STR_ERASE   = "\010 \010";
   localparam logic [8*LEN_ECHO-1:0]    STR_ECHO    = "ECHO: ";
   localparam logic [8*LEN_CRLF-1:0]    STR_CRLF    = "\015\012";
   localparam logic [8*LEN_VERSION-1:0] STR_VERSION = "VERSION: 1.0\015\012";
   localparam logic [8*LEN_STATUS-1:0]  STR_STATUS  = "STATUS: Ready\015\012";
   localparam logic [8*LEN_RESET-1:0]   STR_RESET   = "RESET: OK\015\012";
   localparam logic [8*LEN_ERROR-1:0]   STR_ERROR   = "ERROR: Unknown command\015\012";

   function automatic logic [TXT_POS_W-1:0] text_len(text_type t);
      logic [TXT_POS_W-1:0] n;
      case (t)
         TXT_ERASE:   n = TXT_POS_W'(LEN_ERASE);
         TXT_ECHO:    n = TXT_POS_W'(LEN_ECHO);
         TXT_CRLF:    n = TXT_POS_W'(LEN_CRLF);
         TXT_VERSION: n = TXT_POS_W'(LEN_VERSION);
         TXT_STATUS:  n = TXT_POS_W'(LEN_STATUS);
         TXT_RESET:   n = TXT_POS_W'(LEN_RESET);
         default:     n = TXT_POS_W'(LEN_ERROR);
      endcase
      return n;
   endfunction

   // first character sits in the top byte of each string
   function automatic logic [7:0] text_byte(text_type t, logic [TXT_POS_W-1:0] pos);
      int k;
      logic [7:0] b;
      k = int'(pos);
      case (t)
         TXT_ERASE:   b = STR_ERASE[8*(LEN_ERASE-1-k) +: 8];
         TXT_ECHO:    b = STR_ECHO[8*(LEN_ECHO-1-k) +: 8];
         TXT_CRLF:    b = STR_CRLF[8*(LEN_CRLF-1-k) +: 8];
         TXT_VERSION: b = STR_VERSION[8*(LEN_VERSION-1-k) +: 8];
         TXT_STATUS:  b = STR_STATUS[8*(LEN_STATUS-1-k) +: 8];
         TXT_RESET:   b = STR_RESET[8*(LEN_RESET-1-k) +: 8];
         default:     b = STR_ERROR[8*(LEN_ERROR-1-k) +: 8];
      endcase
      return b;
   endfunction

endpackage

@@ hdl/scl_front.sv @@
// ----------------------------------------------------------------------------
// scl_front
// Accepts received bytes, tracks the line length and first character and
// turns each request into a command for the back end.
// ----------------------------------------------------------------------------
module scl_front #(
   parameter int LINE_DEPTH = scl_pkg::LINE_DEPTH_DEFAULT,
   parameter int IDX_W      = $clog2(LINE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  scl_pkg::q_status_type q_status,
   output logic                 push,
   output scl_pkg::cmd_type     push_cmd,
   output logic [IDX_W-1:0]     push_index
);

   localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(LINE_DEPTH - 1);

   logic [IDX_W-1:0] len_ff, len_in;
   logic [7:0]       first_ff, first_in;
   logic             accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;

   always_comb begin
      len_in            = len_ff;
      first_in          = first_ff;
      push_cmd.op       = scl_pkg::OP_ECHO;
      push_cmd.data     = req_rx_byte;
      push_index        = len_ff;
      if (req_rx_byte inside {scl_pkg::CH_CR, scl_pkg::CH_LF}) begin
         len_in = '0;
         if (len_ff != '0) begin
            case (first_ff)
               scl_pkg::CH_E: push_cmd.op = scl_pkg::OP_LINE_E;
               scl_pkg::CH_V: push_cmd.op = scl_pkg::OP_VERSION;
               scl_pkg::CH_S: push_cmd.op = scl_pkg::OP_STATUS;
               scl_pkg::CH_R: push_cmd.op = scl_pkg::OP_RESET;
               default:       push_cmd.op = scl_pkg::OP_ERROR;
            endcase
         end
      end else if (req_rx_byte inside {scl_pkg::CH_BS, scl_pkg::CH_DEL}) begin
         if (len_ff != '0) begin
            push_cmd.op = scl_pkg::OP_ERASE;
            len_in      = len_ff - 1'b1;
         end
      end else if (len_ff < LEN_MAX) begin
         push_cmd.op = scl_pkg::OP_STORE;
         len_in      = len_ff + 1'b1;
         if (len_ff == '0) begin
            first_in = req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (accept) begin
         len_ff <= len_in;
      end
      if (accept) begin
         first_ff <= first_in;
      end
   end

endmodule

@@ hdl/scl_queue.sv @@
// ----------------------------------------------------------------------------
// scl_queue
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module scl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = scl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output scl_pkg::q_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign pop_data       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/scl_back.sv @@
// ----------------------------------------------------------------------------
// scl_back
// Executes queued commands: echo, line store writes and response texts,
// one character per cycle into the output register unless rsp_stall holds it.
// ----------------------------------------------------------------------------
module scl_back #(
   parameter int LINE_DEPTH = scl_pkg::LINE_DEPTH_DEFAULT,
   parameter int IDX_W      = $clog2(LINE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scl_pkg::q_status_type q_status,
   output logic                  pop,
   input  scl_pkg::cmd_type      pop_cmd,
   input  logic [IDX_W-1:0]      pop_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_last_of_run
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEXT,
      ST_CONTENT
   } state_type;

   localparam int TPW = scl_pkg::TXT_POS_W;

   state_type                state_ff, state_in;
   scl_pkg::text_type        text_ff, text_in;
   logic [TPW-1:0]           pos_ff, pos_in;
   logic                     then_ff, then_in;
   logic [IDX_W-1:0]         len_ff, len_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_byte_ff;
   logic                     rsp_last_ff;

   logic [7:0]               line_mem [LINE_DEPTH];
   logic [7:0]               rd_ff;

   logic                     can_load;
   logic                     emit;
   logic [7:0]               emit_byte;
   logic                     emit_last;
   logic                     wr_en;

   assign can_load        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_byte     = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_comb begin
      state_in  = state_ff;
      text_in   = text_ff;
      pos_in    = pos_ff;
      then_in   = then_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      emit_byte = 8'd0;
      emit_last = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (can_load && !q_status.empty) begin
               pop       = 1'b1;
               emit      = 1'b1;
               emit_byte = pop_cmd.data;
               pos_in    = '0;
               then_in   = 1'b0;
               state_in  = ST_TEXT;
               case (pop_cmd.op)
                  scl_pkg::OP_ECHO: begin
                     emit_last = 1'b1;
                     state_in  = ST_IDLE;
                  end
                  scl_pkg::OP_STORE: begin
                     emit_last = 1'b1;
                     wr_en     = 1'b1;
                     state_in  = ST_IDLE;
                  end
                  scl_pkg::OP_ERASE:   text_in = scl_pkg::TXT_ERASE;
                  scl_pkg::OP_LINE_E: begin
                     text_in = scl_pkg::TXT_ECHO;
                     then_in = 1'b1;
                     len_in  = pop_index;
                  end
                  scl_pkg::OP_VERSION: text_in = scl_pkg::TXT_VERSION;
                  scl_pkg::OP_STATUS:  text_in = scl_pkg::TXT_STATUS;
                  scl_pkg::OP_RESET:   text_in = scl_pkg::TXT_RESET;
                  default:             text_in = scl_pkg::TXT_ERROR;
               endcase
            end
         end
         ST_TEXT: begin
            if (can_load) begin
               emit      = 1'b1;
               emit_byte = scl_pkg::text_byte(text_ff, pos_ff);
               if (pos_ff == TPW'(scl_pkg::text_len(text_ff) - 1'b1)) begin
                  emit_last = !then_ff;
                  if (then_ff) begin
                     state_in = ST_CONTENT;
                     idx_in   = IDX_W'(1);
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_CONTENT: begin
            if (can_load) begin
               emit = 1'b1;
               if (idx_ff >= len_ff || rd_ff == scl_pkg::CH_NUL) begin
                  // end of line text: carriage return now, line feed next
                  emit_byte = scl_pkg::CH_CR;
                  state_in  = ST_TEXT;
                  text_in   = scl_pkg::TXT_CRLF;
                  pos_in    = TPW'(1);
                  then_in   = 1'b0;
               end else begin
                  emit_byte = rd_ff;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (can_load) begin
            rsp_valid_ff <= emit;
         end
      end
      text_ff <= text_in;
      pos_ff  <= pos_in;
      then_ff <= then_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      if (can_load) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
      end
   end

   // line store, read data follows the next index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[pop_index] <= pop_cmd.data;
      end
      rd_ff <= line_mem[idx_in];
   end

endmodule

@@ hdl/serial_command_line_responder.sv @@
// ----------------------------------------------------------------------------
// serial_command_line_responder
// Line editor and command responder for a serial console.
// ----------------------------------------------------------------------------
// Each request carries one received byte on req_rx_byte. The block answers
// with a run of responses on rsp_tx_byte: the echo first, then an erase
// sequence or a command answer; rsp_last_of_run marks the final byte of a run.
// A front end classifies the byte and tracks the line, a four-entry command
// queue follows; a back end sequencer emits one byte per cycle unless stalled.
// The front end handles a request combinationally; its run has from 1 up to
// 39 bytes at the default line depth (ECHO answers: 9 plus the stored text).
// The back end sequencer, one byte a cycle through the output register, sets
// the sustained rate.
// Reset empties the line and the queue; no clearing pass is needed, since the
// line store is only read where it was written.
// When rsp_stall is high the output register holds its byte; the back end
// waits, the queue fills, and req_stall rises once four commands are waiting.
// ----------------------------------------------------------------------------
module serial_command_line_responder #(
   parameter int LINE_DEPTH  = scl_pkg::LINE_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_of_run
);

   localparam int IDX_W = $clog2(LINE_DEPTH);
   localparam int Q_W   = $bits(scl_pkg::cmd_type) + IDX_W;

   scl_pkg::q_status_type q_status;
   scl_pkg::cmd_type      push_cmd, pop_cmd;
   logic [IDX_W-1:0]      push_index, pop_index;
   logic                  push, pop;
   logic [Q_W-1:0]        pop_data;

   scl_front #(
      .LINE_DEPTH (LINE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_index  (push_index)
   );

   scl_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_index}),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   assign pop_cmd   = pop_data[Q_W-1:IDX_W];
   assign pop_index = pop_data[IDX_W-1:0];

   scl_back #(
      .LINE_DEPTH (LINE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop             (pop),
      .pop_cmd         (pop_cmd),
      .pop_index       (pop_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ hdl/scl_checker.sv @@
// ----------------------------------------------------------------------------
// scl_checker
// Port level checks of the serial command line responder.
// ----------------------------------------------------------------------------
module scl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last_of_run
);

   // no response right after reset
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // queue is empty after reset, so requests are taken
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // a run is never broken by a gap
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a response run");

endmodule

bind serial_command_line_responder scl_checker u_scl_checker (.*);

@@ tb/tb_serial_command_line_responder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_command_line_responder
// Drives received bytes into the command line responder and checks every
// transmitted byte and end-of-run flag against a line-editing predictor.
// A short directed sequence covers empty lines, erase, every command, a zero
// byte in an ECHO line and an overfilled line, then random command lines mixed
// with noise, under changing idle patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_serial_command_line_responder;

   localparam int LINE_MAX       = scl_pkg::LINE_DEPTH_DEFAULT - 1;
   localparam int TOTAL_ITEMS    = 200;
   localparam int HOLD_OFF_AT    = 40;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;

   localparam string ERASE_SEQ    = "\010 \010";
   localparam string ECHO_PREFIX  = "ECHO: ";
   localparam string LINE_END     = "\015\012";
   localparam string VERSION_TEXT = "VERSION: 1.0\015\012";
   localparam string STATUS_TEXT  = "STATUS: Ready\015\012";
   localparam string RESET_TEXT   = "RESET: OK\015\012";
   localparam string ERROR_TEXT   = "ERROR: Unknown command\015\012";

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_of_run;
   } tx_char_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last_of_run;

   logic [7:0]  rx_pending[$];
   tx_char_type tx_expected[$];
   logic [7:0]  run_chars[$];
   logic [7:0]  line_chars[scl_pkg::LINE_DEPTH_DEFAULT];
   int          line_len     = 0;
   int          n_total      = 0;
   int          n_accepted   = 0;
   int          n_fail       = 0;
   int          hold_left    = 0;
   bit          hold_done    = 1'b0;
   int          idle_cycles  = 0;

   serial_command_line_responder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #1 clock = ~clock;

   function void append_text(string s);
      for (int k = 0; k < s.len(); k++) run_chars.push_back(s[k]);
   endfunction

   // line editor: echo, then erase or command answer
   function void respond_to_byte(logic [7:0] c);
      int i;
      run_chars.delete();
      run_chars.push_back(c);
      if (c == scl_pkg::CH_CR || c == scl_pkg::CH_LF) begin
         if (line_len > 0) begin
            case (line_chars[0])
               scl_pkg::CH_E: begin
                  append_text(ECHO_PREFIX);
                  i = 1;
                  while (i < line_len && line_chars[i] != scl_pkg::CH_NUL) begin
                     run_chars.push_back(line_chars[i]);
                     i++;
                  end
                  append_text(LINE_END);
               end
               scl_pkg::CH_V: append_text(VERSION_TEXT);
               scl_pkg::CH_S: append_text(STATUS_TEXT);
               scl_pkg::CH_R: append_text(RESET_TEXT);
               default: append_text(ERROR_TEXT);
            endcase
         end
         line_len = 0;
      end else if (c == scl_pkg::CH_BS || c == scl_pkg::CH_DEL) begin
         if (line_len > 0) begin
            line_len--;
            append_text(ERASE_SEQ);
         end
      end else if (line_len < LINE_MAX) begin
         line_chars[line_len] = c;
         line_len++;
      end
      for (int k = 0; k < run_chars.size(); k++)
         tx_expected.push_back('{run_chars[k], k == run_chars.size() - 1});
   endfunction

   function void queue_line(logic [7:0] head, int body_len);
      logic [7:0] c;
      int unsigned r;
      rx_pending.push_back(head);
      for (int k = 0; k < body_len; k++) begin
         r = $urandom_range(99);
         if (r < 6) begin
            c = scl_pkg::CH_BS;
         end else if (r < 10) begin
            c = scl_pkg::CH_DEL;
         end else if (r < 14) begin
            c = scl_pkg::CH_NUL;
         end else begin
            do c = 8'($urandom_range(255));
            while (c == scl_pkg::CH_CR || c == scl_pkg::CH_LF ||
                   c == scl_pkg::CH_BS || c == scl_pkg::CH_DEL);
         end
         rx_pending.push_back(c);
      end
      rx_pending.push_back($urandom_range(1) ? scl_pkg::CH_CR : scl_pkg::CH_LF);
   endfunction

   function int phase_of_run();
      if (n_accepted < n_total / 3) return 0;
      if (n_accepted < 2 * n_total / 3) return 1;
      return 2;
   endfunction

   function int send_idle_pct();
      case (phase_of_run())
         0: return 19;
         1: return 70;
         default: return 0;
      endcase
   endfunction

   function int recv_idle_pct();
      case (phase_of_run())
         0: return 70;
         1: return 19;
         default: return 0;
      endcase
   endfunction

   function void note_failure(tx_char_type want, tx_char_type got, bit none_waiting);
      if (n_fail < 10) begin
         if (none_waiting)
            $display("unexpected response: tx_byte %02h last_of_run %0b",
                     got.tx_byte, got.last_of_run);
         else
            $display("mismatch: tx_byte exp %02h got %02h, last_of_run exp %0b got %0b",
                     want.tx_byte, got.tx_byte, want.last_of_run, got.last_of_run);
      end
      n_fail++;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= HOLD_OFF_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_LEN;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct());
      end
   end

   // monitor: predict on each request, check each response
   always @(posedge clock) begin
      tx_char_type got;
      tx_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            respond_to_byte(req_rx_byte);
            n_accepted <= n_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_tx_byte, rsp_last_of_run};
            if (tx_expected.size() == 0) begin
               note_failure(got, got, 1'b1);
            end else begin
               want = tx_expected.pop_front();
               if (got.tx_byte !== want.tx_byte || got.last_of_run !== want.last_of_run)
                  note_failure(want, got, 1'b0);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0] head;

      // empty line, erase on empty line, every command, zero byte, extremes
      rx_pending = {rx_pending, scl_pkg::CH_CR, scl_pkg::CH_BS, scl_pkg::CH_DEL};
      rx_pending = {rx_pending, scl_pkg::CH_V, scl_pkg::CH_CR, scl_pkg::CH_S,
                    scl_pkg::CH_LF, scl_pkg::CH_R, scl_pkg::CH_CR};
      rx_pending = {rx_pending, scl_pkg::CH_E, 8'h68, 8'h69, scl_pkg::CH_NUL, 8'h78,
                    scl_pkg::CH_CR};
      rx_pending = {rx_pending, 8'h71, scl_pkg::CH_BS, scl_pkg::CH_E, 8'h61,
                    scl_pkg::CH_DEL, 8'h62, scl_pkg::CH_LF};
      rx_pending = {rx_pending, 8'hFF, scl_pkg::CH_CR, scl_pkg::CH_E, scl_pkg::CH_LF};

      // overfilled echo line
      rx_pending.push_back(scl_pkg::CH_E);
      for (int k = 0; k < 40; k++) rx_pending.push_back(8'($urandom_range(32, 126)));
      rx_pending.push_back(scl_pkg::CH_CR);

      while (rx_pending.size() < TOTAL_ITEMS) begin
         if ($urandom_range(99) < 75) begin
            case ($urandom_range(4))
               0: head = scl_pkg::CH_E;
               1: head = scl_pkg::CH_V;
               2: head = scl_pkg::CH_S;
               3: head = scl_pkg::CH_R;
               default: begin
                  do head = 8'($urandom_range(255));
                  while (head == scl_pkg::CH_CR || head == scl_pkg::CH_LF ||
                         head == scl_pkg::CH_BS || head == scl_pkg::CH_DEL);
               end
            endcase
            queue_line(head, ($urandom_range(7) == 0) ? $urandom_range(25, 40)
                                                       : $urandom_range(0, 8));
         end else begin
            repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom_range(255)));
         end
      end
      n_total = rx_pending.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (n_accepted < n_total || tx_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_fail == 0 && tx_expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/scl_pkg.sv
hdl/scl_front.sv
hdl/scl_queue.sv
hdl/scl_back.sv
hdl/serial_command_line_responder.sv
hdl/scl_checker.sv
tb/tb_serial_command_line_responder.sv
